### src/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every rising clock edge outside reset.
`define E2E_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Checks that a consequence holds at the rising clock edge after its antecedent.
`define E2E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/e2ecrc_pkg.sv
// Types, codes and CRC-64 tables for the E2E protect and check block.
package e2ecrc_pkg;

  localparam int CRC_W        = 64;
  localparam int CNT_W        = 16;
  localparam int ID_W         = 32;
  localparam int DELTA_W      = 16;
  localparam int POS_W        = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 32;
  localparam int TABLE_SIZE   = 256;
  localparam int HEADER_BYTES = 16;
  localparam int HDR_CRC_BYTES = 8;
  localparam int CNT_LO_POS   = 8;
  localparam int CNT_HI_POS   = 9;
  localparam logic [CRC_W-1:0] CRC_POLY = 64'hC96C5795D7870F42;

  typedef enum logic [1:0] {
    FUNC_PROTECT = 2'd0,
    FUNC_FORWARD = 2'd1,
    FUNC_CHECK   = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_REPEATED    = 3'd1,
    ST_WRONG_SEQ   = 3'd2,
    ST_WRONG_CRC   = 3'd3,
    ST_NO_NEW_DATA = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DATA_ID   = 1'b0,
    REG_MAX_DELTA = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [CRC_W-1:0] crc_value;
    logic [CNT_W-1:0] counter_value;
    logic [2:0]       status;
  } out_t;

  typedef struct packed {
    logic [CRC_W-1:0]   id_crc;
    logic [DELTA_W-1:0] max_delta;
  } cfg_t;

  typedef logic [CRC_W-1:0] crc_tab_t [TABLE_SIZE];
  typedef logic [CRC_W-1:0] id_cols_t [ID_W];
  typedef logic [CRC_W-1:0] cnt_cols_t [CNT_W];

  // Bit-serial byte update, used only to build the constant tables.
  function automatic logic [CRC_W-1:0] crc_run(logic [CRC_W-1:0] crc, logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {56'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic crc_tab_t gen_table();
    crc_tab_t t;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      t[i] = crc_run('0, 8'(i));
    end
    return t;
  endfunction

  // Column k is the CRC of the data id with only bit k set, followed by two zero bytes.
  function automatic id_cols_t gen_id_cols();
    id_cols_t         t;
    logic [ID_W-1:0]  w;
    logic [CRC_W-1:0] c;
    for (int k = 0; k < ID_W; k++) begin
      w = ID_W'(1) << k;
      c = '0;
      for (int j = 0; j < ID_W / 8; j++) begin
        c = crc_run(c, w[8*j +: 8]);
      end
      c = crc_run(c, 8'd0);
      c = crc_run(c, 8'd0);
      t[k] = c;
    end
    return t;
  endfunction

  // Column k is the CRC of a counter with only bit k set.
  function automatic cnt_cols_t gen_cnt_cols();
    cnt_cols_t        t;
    logic [CNT_W-1:0] w;
    logic [CRC_W-1:0] c;
    for (int k = 0; k < CNT_W; k++) begin
      w = CNT_W'(1) << k;
      c = crc_run('0, w[7:0]);
      c = crc_run(c, w[15:8]);
      t[k] = c;
    end
    return t;
  endfunction

  localparam crc_tab_t  CRC_TABLE = gen_table();
  localparam id_cols_t  ID_COLS   = gen_id_cols();
  localparam cnt_cols_t CNT_COLS  = gen_cnt_cols();

  function automatic logic [CRC_W-1:0] crc_byte(logic [CRC_W-1:0] crc, logic [7:0] b);
    return (crc >> 8) ^ CRC_TABLE[crc[7:0] ^ b];
  endfunction

  function automatic logic [CRC_W-1:0] id_crc(logic [ID_W-1:0] id);
    logic [CRC_W-1:0] c;
    c = '0;
    for (int k = 0; k < ID_W; k++) begin
      if (id[k]) begin
        c = c ^ ID_COLS[k];
      end
    end
    return c;
  endfunction

  function automatic logic [CRC_W-1:0] cnt_crc(logic [CNT_W-1:0] cnt);
    logic [CRC_W-1:0] c;
    c = '0;
    for (int k = 0; k < CNT_W; k++) begin
      if (cnt[k]) begin
        c = c ^ CNT_COLS[k];
      end
    end
    return c;
  endfunction

endpackage

### src/e2ecrc_cfg.sv
// Configuration registers; the data id is kept as its CRC contribution.
module e2ecrc_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [e2ecrc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [e2ecrc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output e2ecrc_pkg::cfg_t                     cfg_o
);
  import e2ecrc_pkg::*;

  logic [CRC_W-1:0]   id_crc_q;
  logic [DELTA_W-1:0] max_delta_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_crc_q    <= '0;
      max_delta_q <= DELTA_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DATA_ID: begin
          id_crc_q <= id_crc(cfg_data_i[ID_W-1:0]);
        end
        REG_MAX_DELTA: begin
          max_delta_q <= cfg_data_i[DELTA_W-1:0];
        end
      endcase
    end
  end

  assign cfg_o.id_crc    = id_crc_q;
  assign cfg_o.max_delta = max_delta_q;

endmodule

### src/e2ecrc_engine.sv
// Message state and the per-byte protect, forward and check logic.
module e2ecrc_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  e2ecrc_pkg::in_t   item_i,
  input  e2ecrc_pkg::cfg_t  cfg_i,
  output e2ecrc_pkg::out_t  res_o
);
  import e2ecrc_pkg::*;

  logic [CNT_W-1:0] snd_q, snd_d;
  logic [CNT_W-1:0] rcv_q, rcv_d;
  logic [CRC_W-1:0] crc_q, crc_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [CRC_W-1:0] hcrc_q, hcrc_d;
  logic [CNT_W-1:0] hcnt_q, hcnt_d;
  logic [1:0]       mode_q, mode_d;

  logic             pos0;
  logic             pf;
  logic             had_payload;
  logic [CNT_W-1:0] cnt_new;
  logic [CRC_W-1:0] crc_base;
  logic [CNT_W-1:0] delta;

  always_comb begin
    snd_d    = snd_q;
    rcv_d    = rcv_q;
    crc_d    = crc_q;
    hcrc_d   = hcrc_q;
    hcnt_d   = hcnt_q;
    res_o    = '0;
    cnt_new  = snd_q;
    crc_base = crc_q;
    delta    = hcnt_q - rcv_q;

    pos0        = (pos_q == '0);
    mode_d      = pos0 ? item_i.func : mode_q;
    pf          = (mode_d == FUNC_PROTECT) || (mode_d == FUNC_FORWARD);
    had_payload = (pos_q >= POS_W'(HEADER_BYTES));

    if (pos_q < POS_W'(HEADER_BYTES)) begin
      pos_d = pos_q + POS_W'(1);
    end else begin
      pos_d = pos_q;
    end
    if (item_i.last) begin
      pos_d = '0;
    end

    if (pf) begin
      if (pos0) begin
        if (mode_d == FUNC_PROTECT) begin
          cnt_new = snd_q + CNT_W'(1);
        end else begin
          cnt_new = rcv_q;
        end
        crc_base = cfg_i.id_crc ^ cnt_crc(cnt_new);
      end
      crc_d               = crc_byte(crc_base, item_i.data_byte);
      snd_d               = cnt_new;
      res_o.crc_value     = crc_d;
      res_o.counter_value = cnt_new;
      res_o.status        = ST_OK;
    end else begin
      if (pos_q < POS_W'(HDR_CRC_BYTES)) begin
        hcrc_d[{pos_q[2:0], 3'b000} +: 8] = item_i.data_byte;
      end else if (pos_q == POS_W'(CNT_LO_POS)) begin
        hcnt_d[7:0] = item_i.data_byte;
      end else if (pos_q == POS_W'(CNT_HI_POS)) begin
        hcnt_d[15:8] = item_i.data_byte;
        crc_d = cfg_i.id_crc ^ cnt_crc({item_i.data_byte, hcnt_q[7:0]});
      end else if (had_payload) begin
        crc_d = crc_byte(crc_q, item_i.data_byte);
      end

      if (!had_payload) begin
        res_o.status = ST_NO_NEW_DATA;
      end else begin
        res_o.crc_value     = crc_d;
        res_o.counter_value = hcnt_q;
        if (hcrc_q != crc_d) begin
          res_o.status = ST_WRONG_CRC;
        end else begin
          rcv_d = hcnt_q;
          priority if (delta == '0) begin
            res_o.status = ST_REPEATED;
          end else if (delta > cfg_i.max_delta) begin
            res_o.status = ST_WRONG_SEQ;
          end else begin
            res_o.status = ST_OK;
          end
        end
      end
      if (!item_i.last) begin
        rcv_d = rcv_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snd_q  <= '0;
      rcv_q  <= '0;
      crc_q  <= '0;
      pos_q  <= '0;
      hcrc_q <= '0;
      hcnt_q <= '0;
      mode_q <= '0;
    end else if (fire_i) begin
      snd_q  <= snd_d;
      rcv_q  <= rcv_d;
      crc_q  <= crc_d;
      pos_q  <= pos_d;
      hcrc_q <= hcrc_d;
      hcnt_q <= hcnt_d;
      mode_q <= mode_d;
    end
  end

endmodule

### src/e2e_crc64_protect_check_core.sv
// Top level of the byte-serial CRC-64 E2E protect, forward and check block.
//
// The input channel carries one message byte per item with the operation and a
// last marker; the operation is taken from the first byte of each message.
// Protect and forward give one result on the last byte with the CRC and the
// counter; check gives one result on the last byte with a status.
// The configuration channel writes the data id (index 0) or the largest
// accepted counter jump (index 1); it is always ready. It is to be written while
// idle, a rule for the user that the block does not enforce. An accepted item
// lands in an input register, is processed from there through one CRC table
// step once it may move on, and a last byte's result is then held in the output
// register. One item is taken per cycle, set by the single byte-wide CRC table
// step, unless a last byte waits: when the receiver stalls, the result is held
// and bytes without a result keep flowing; a last byte waits in the input register
// until the output frees up. Reset clears all counters, the running CRC and the
// message position, sets the data id to zero and the largest counter jump to one.
module e2e_crc64_protect_check_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  e2ecrc_pkg::in_t                      in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output e2ecrc_pkg::out_t                     out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [e2ecrc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [e2ecrc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import e2ecrc_pkg::*;

  logic in_valid_q;
  in_t  in_q;
  logic out_valid_q, out_valid_d;
  out_t out_q;
  out_t res;
  cfg_t cfg;
  logic fire;

  e2ecrc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  e2ecrc_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign fire       = in_valid_q && (!in_q.last || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (fire && in_q.last) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (fire && in_q.last) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### src/e2ecrc_checker.sv
// Port-level assertions for the E2E protect and check block, bound to its top level.
`include "assert_macros.svh"

module e2ecrc_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input e2ecrc_pkg::out_t out_data_o
);
  import e2ecrc_pkg::*;

  `E2E_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o))

  `E2E_ASSERT(a_status_range, clk_i, rst_ni, !out_valid_o || out_data_o.status == ST_OK || out_data_o.status == ST_REPEATED || out_data_o.status == ST_WRONG_SEQ || out_data_o.status == ST_WRONG_CRC || out_data_o.status == ST_NO_NEW_DATA)

  `E2E_ASSERT(a_short_zero, clk_i, rst_ni, !(out_valid_o && out_data_o.status == ST_NO_NEW_DATA) || (out_data_o.crc_value == '0 && out_data_o.counter_value == '0))

endmodule

bind e2e_crc64_protect_check_core e2ecrc_checker u_checker (.*);

### dv/testbench.sv
// Self-checking testbench for the CRC-64 E2E protect, forward and check block.
module testbench;
  import e2ecrc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BYTES = 210;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  in_t in_data = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  out_t out_data_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  in_t bytes_to_send[$];
  out_t results_due[$];
  int items_pushed = 0;
  int items_taken = 0;
  int results_checked = 0;
  int mismatches = 0;
  int settings_used = 1;
  int status_seen[5] = '{default: 0};
  int idle_cycles = 0;
  bit stalled = 1'b0;
  logic in_taken = 1'b0;

  bit no_gaps = 1'b0;
  bit pressure_phase = 1'b0;
  bit pressure_done = 1'b0;
  int send_gap = 0;
  int sink_gap = 0;
  int hold_left = 0;

  // Stimulus-side view of the configuration and of the last good check counter.
  logic [31:0] cur_id = '0;
  logic [15:0] cur_max = 16'd1;
  logic [15:0] gen_rx = '0;

  // Predictor state.
  logic [31:0] id_reg = '0;
  logic [15:0] max_reg = 16'd1;
  logic [15:0] tx_cnt = '0;
  logic [15:0] rx_cnt = '0;
  logic [63:0] run_crc = '0;
  logic [4:0] pos = '0;
  logic [63:0] hdr_crc = '0;
  logic [15:0] hdr_cnt = '0;
  logic [1:0] mode = '0;

  e2e_crc64_protect_check_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] crc64_byte(input logic [63:0] crc, input logic [7:0] b);
    logic [63:0] c;
    c = crc ^ {56'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [63:0] crc_seed(input logic [31:0] id, input logic [15:0] cnt);
    logic [47:0] s;
    logic [63:0] c;
    s = {cnt, id};
    c = '0;
    for (int k = 0; k < 6; k++) begin
      c = crc64_byte(c, s[8*k +: 8]);
    end
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic track_byte(input in_t it);
    out_t r;
    bit had_payload;
    logic [15:0] delta;
    if (pos == 0) begin
      mode = it.func;
    end
    if (mode == FUNC_PROTECT || mode == FUNC_FORWARD) begin
      if (pos == 0) begin
        if (mode == FUNC_PROTECT) begin
          tx_cnt = tx_cnt + 16'd1;
        end else begin
          tx_cnt = rx_cnt;
        end
        run_crc = crc_seed(id_reg, tx_cnt);
      end
      run_crc = crc64_byte(run_crc, it.data_byte);
      if (pos < HEADER_BYTES) begin
        pos = pos + 5'd1;
      end
      if (!it.last) begin
        return;
      end
      pos = '0;
      r.crc_value = run_crc;
      r.counter_value = tx_cnt;
      r.status = ST_OK;
    end else begin
      if (pos < HDR_CRC_BYTES) begin
        hdr_crc[8*pos +: 8] = it.data_byte;
      end else if (pos == CNT_LO_POS) begin
        hdr_cnt[7:0] = it.data_byte;
      end else if (pos == CNT_HI_POS) begin
        hdr_cnt[15:8] = it.data_byte;
        run_crc = crc_seed(id_reg, hdr_cnt);
      end else if (pos >= HEADER_BYTES) begin
        run_crc = crc64_byte(run_crc, it.data_byte);
      end
      had_payload = (pos >= HEADER_BYTES);
      if (pos < HEADER_BYTES) begin
        pos = pos + 5'd1;
      end
      if (!it.last) begin
        return;
      end
      pos = '0;
      if (!had_payload) begin
        r.crc_value = '0;
        r.counter_value = '0;
        r.status = ST_NO_NEW_DATA;
      end else begin
        r.crc_value = run_crc;
        r.counter_value = hdr_cnt;
        if (hdr_crc != run_crc) begin
          r.status = ST_WRONG_CRC;
        end else begin
          delta = hdr_cnt - rx_cnt;
          if (delta == 0) begin
            r.status = ST_REPEATED;
          end else if (delta > max_reg) begin
            r.status = ST_WRONG_SEQ;
          end else begin
            r.status = ST_OK;
          end
          rx_cnt = hdr_cnt;
        end
      end
    end
    status_seen[r.status]++;
    results_due.insert(results_due.size(), r);
  endtask

  // Monitor: predicts on accepted bytes and compares accepted results.
  always @(posedge clk) begin
    out_t exp_r;
    bit any;
    in_taken <= rst_n && in_valid && in_ready_o;
    if (rst_n) begin
      any = 1'b0;
      if (cfg_valid && cfg_ready_o) begin
        any = 1'b1;
        if (cfg_index == REG_DATA_ID) begin
          id_reg = cfg_data;
        end else begin
          max_reg = cfg_data[15:0];
        end
      end
      if (in_valid && in_ready_o) begin
        any = 1'b1;
        track_byte(in_data);
        items_taken++;
      end
      if (out_valid_o && out_ready) begin
        any = 1'b1;
        results_checked++;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected result: crc %h counter %h status %0d",
                     out_data_o.crc_value, out_data_o.counter_value, out_data_o.status);
          end
        end else begin
          exp_r = results_due.pop_front();
          if (out_data_o.crc_value !== exp_r.crc_value ||
              out_data_o.counter_value !== exp_r.counter_value ||
              out_data_o.status !== exp_r.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch on result %0d: expected crc %h counter %h status %0d",
                       results_checked, exp_r.crc_value, exp_r.counter_value, exp_r.status);
              $display("  got crc %h counter %h status %0d",
                       out_data_o.crc_value, out_data_o.counter_value, out_data_o.status);
            end
          end
        end
      end
      idle_cycles = any ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        stalled = 1'b1;
      end
    end
  end

  // Driver: offers queued bytes with random gaps between them.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (bytes_to_send.size() != 0) begin
        in_data <= bytes_to_send.pop_front();
        in_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink: random back-pressure plus one long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (pressure_phase && !pressure_done) begin
      pressure_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      sink_gap = pick_gap();
    end
  end

  task automatic push_byte(input logic [1:0] f, input logic [7:0] b, input bit is_last);
    in_t it;
    it.func = f;
    it.data_byte = b;
    it.last = is_last;
    bytes_to_send.insert(bytes_to_send.size(), it);
    items_pushed++;
  endtask

  task automatic push_plain(input logic [1:0] f, input int n);
    for (int i = 0; i < n; i++) begin
      push_byte((i == 0) ? f : 2'($urandom), 8'($urandom), i == n - 1);
    end
  endtask

  function automatic logic [1:0] check_code();
    return $urandom_range(1) ? FUNC_CHECK : FUNC_UNUSED;
  endfunction

  task automatic push_check(input int n_pay, input logic [15:0] cnt, input bit corrupt);
    logic [63:0] crc;
    logic [7:0] pay[$];
    logic [7:0] b;
    crc = crc_seed(cur_id, cnt);
    for (int i = 0; i < n_pay; i++) begin
      b = 8'($urandom);
      pay.insert(pay.size(), b);
      crc = crc64_byte(crc, b);
    end
    if (corrupt) begin
      crc = crc ^ (64'd1 << $urandom_range(63));
    end else begin
      gen_rx = cnt;
    end
    for (int i = 0; i < HDR_CRC_BYTES; i++) begin
      push_byte((i == 0) ? check_code() : 2'($urandom), crc[8*i +: 8], 1'b0);
    end
    push_byte(2'($urandom), cnt[7:0], 1'b0);
    push_byte(2'($urandom), cnt[15:8], 1'b0);
    for (int i = CNT_HI_POS + 1; i < HEADER_BYTES; i++) begin
      push_byte(2'($urandom), 8'($urandom), 1'b0);
    end
    for (int i = 0; i < n_pay; i++) begin
      push_byte(2'($urandom), pay[i], i == n_pay - 1);
    end
  endtask

  task automatic push_short_check(input int n);
    for (int i = 0; i < n; i++) begin
      push_byte((i == 0) ? check_code() : 2'($urandom), 8'($urandom), i == n - 1);
    end
  endtask

  function automatic int rand_len();
    return ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
  endfunction

  function automatic logic [15:0] next_rx_cnt();
    case ($urandom_range(4))
      0: return gen_rx;
      1: return gen_rx + 16'd1;
      2: return gen_rx + cur_max;
      3: return gen_rx + cur_max + 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_traffic(input int n_bytes);
    int start;
    int r;
    start = items_pushed;
    while (items_pushed - start < n_bytes) begin
      r = $urandom_range(99);
      if (r < 30) begin
        push_plain(FUNC_PROTECT, rand_len());
      end else if (r < 42) begin
        push_plain(FUNC_FORWARD, rand_len());
      end else if (r < 82) begin
        push_check(rand_len(), next_rx_cnt(), 1'b0);
      end else if (r < 90) begin
        push_check(rand_len(), 16'($urandom), 1'b1);
      end else begin
        push_short_check($urandom_range(1, HEADER_BYTES));
      end
    end
  endtask

  task automatic wait_idle();
    while (items_taken != items_pushed || results_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready_o) begin
      @(posedge clk);
    end
  endtask

  task automatic run_all();
    logic [31:0] id;
    logic [15:0] md;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    push_plain(FUNC_PROTECT, 1);
    bytes_to_send[bytes_to_send.size() - 1].data_byte = 8'h00;
    push_byte(FUNC_PROTECT, 8'hFF, 1'b0);
    push_byte(FUNC_UNUSED, 8'h5A, 1'b1);
    push_plain(FUNC_FORWARD, 1);
    push_short_check(1);
    // A jump from zero to the top counter value, then forward and protect to wrap it.
    push_check(1, 16'hFFFF, 1'b0);
    push_plain(FUNC_FORWARD, 1);
    push_plain(FUNC_PROTECT, 1);
    for (int p = 1; p <= RANDOM_PHASES; p++) begin
      wait_idle();
      case (p)
        1: begin
          id = '1;
          md = '0;
        end
        2: begin
          id = $urandom;
          md = '1;
        end
        RANDOM_PHASES: begin
          id = '0;
          md = 16'($urandom_range(2, 20));
        end
        default: begin
          id = $urandom;
          md = (p % 2) ? 16'd1 : 16'($urandom);
        end
      endcase
      write_reg(REG_DATA_ID, id);
      write_reg(REG_MAX_DELTA, {16'($urandom), md});
      @(negedge clk);
      cfg_valid <= 1'b0;
      cur_id = id;
      cur_max = md;
      settings_used++;
      @(posedge clk);
      no_gaps = (p == 3 || p == 6);
      pressure_phase = (p == 4);
      random_traffic(PHASE_BYTES);
    end
    while (items_taken != items_pushed || results_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (10) @(negedge clk);
  endtask

  initial begin
    fork
      run_all();
      wait (stalled);
    join_any
    if (stalled) begin
      $display("Timed out after %0d cycles without a handshake.", STALL_LIMIT);
    end
    $display("Sent %0d bytes under %0d register settings and checked %0d results.",
             items_taken, settings_used, results_checked);
    $display("Statuses: ok %0d, repeated %0d, wrong sequence %0d, wrong crc %0d, no data %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (stalled || mismatches != 0 || results_due.size() != 0) begin
      $display("%0d mismatches, %0d results never arrived.", mismatches, results_due.size());
      $display("FAILED: results differ");
    end else begin
      $display("PASSED: all results match");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/e2ecrc_pkg.sv
src/e2ecrc_cfg.sv
src/e2ecrc_engine.sv
src/e2e_crc64_protect_check_core.sv
src/e2ecrc_checker.sv
dv/testbench.sv
